// ----- design/esd_pkg.sv -----
// Shared types, character codes and helpers for the escape sequence decoder.
package esd_pkg;

   localparam int CHAR_W     = 8;
   localparam int OUT_W      = 9;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_X   = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_ZERO      = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_SEVEN     = 8'h37;

   localparam logic [OUT_W-1:0] CODE_BACKSPACE = 9'd8;
   localparam logic [OUT_W-1:0] CODE_TAB       = 9'd9;
   localparam logic [OUT_W-1:0] CODE_NEWLINE   = 9'd10;
   localparam logic [OUT_W-1:0] CODE_FORMFEED  = 9'd12;
   localparam logic [OUT_W-1:0] CODE_RETURN    = 9'd13;

   localparam logic [1:0] HEX_FULL_COUNT = 2'd2;
   localparam logic [1:0] OCT_FULL_COUNT = 2'd3;

   typedef enum logic [3:0] {
      MODE_NORMAL = 4'b0001,
      MODE_ESC    = 4'b0010,
      MODE_HEX    = 4'b0100,
      MODE_OCT    = 4'b1000
   } esd_mode_type;

   // One queued step: up to two results, end flag on the last of them
   typedef struct packed {
      logic             two;
      logic [OUT_W-1:0] char0;
      logic             has0;
      logic [OUT_W-1:0] char1;
      logic             eos;
   } esd_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } esd_qstat_type;

   // {valid, digit value}
   function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] diff;
      logic [4:0]        res;
      res  = 5'd0;
      diff = 8'd0;
      if (c inside {[8'h30:8'h39]}) begin
         diff = CHAR_W'(c - CHAR_ZERO);
         res  = {1'b1, diff[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
         diff = CHAR_W'(c - 8'h37);
         res  = {1'b1, diff[3:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
         diff = CHAR_W'(c - 8'h57);
         res  = {1'b1, diff[3:0]};
      end
      return res;
   endfunction

endpackage

// ----- design/esd_if.sv -----
// Valid/ready channel interfaces for requests, responses and the control register.
interface esd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       in_last;
   modport source (output valid, in_char, in_last, input ready);
   modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface esd_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] out_char;
   logic       has_char;
   logic       end_of_string;
   modport source (output valid, out_char, has_char, end_of_string, input ready);
   modport sink   (input valid, out_char, has_char, end_of_string, output ready);
endinterface

interface esd_csr_if;
   logic valid;
   logic ready;
   logic escape_enable;
   modport source (output valid, escape_enable, input ready);
   modport sink   (input valid, escape_enable, output ready);
endinterface

// ----- design/esd_front.sv -----
// Front end: accepts characters, tracks escape state and builds queue entries.
module esd_front
   import esd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   esd_req_if.sink       req_ch,
   input  logic          escape_enable,
   input  esd_qstat_type q_stat,
   output logic          q_push,
   output esd_entry_type q_entry
);

   esd_mode_type     mode_ff, mode_in;
   logic [OUT_W-1:0] value_ff, value_in;
   logic [1:0]       count_ff, count_in;

   logic             accept;
   logic [1:0]       n_res;
   logic [4:0]       hex_d;
   logic [OUT_W-1:0] hex_val, oct_val;
   logic [1:0]       count_inc;
   logic [OUT_W-1:0] c_ext;
   logic             is_oct;

   assign req_ch.ready = !q_stat.full;
   assign accept       = req_ch.valid && req_ch.ready;

   assign c_ext     = {1'b0, req_ch.in_char};
   assign hex_d     = hex_digit(req_ch.in_char);
   assign hex_val   = {value_ff[4:0], hex_d[3:0]};
   assign oct_val   = {value_ff[5:0], req_ch.in_char[2:0]};
   assign count_inc = count_ff + 2'd1;
   assign is_oct    = req_ch.in_char inside {[CHAR_ZERO:CHAR_SEVEN]};

   always_comb begin
      mode_in  = mode_ff;
      value_in = value_ff;
      count_in = count_ff;
      n_res    = 2'd0;
      q_entry  = '0;
      q_entry.has0 = 1'b1;

      if (!escape_enable) begin
         mode_in  = MODE_NORMAL;
         value_in = '0;
         count_in = '0;
         q_entry.char0 = c_ext;
         n_res = 2'd1;
      end else begin
         case (mode_ff)
            MODE_NORMAL: begin
               if (req_ch.in_char == CHAR_BACKSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  q_entry.char0 = c_ext;
                  n_res = 2'd1;
               end
            end
            MODE_ESC: begin
               mode_in = MODE_NORMAL;
               case (req_ch.in_char)
                  CHAR_LOWER_B: begin q_entry.char0 = CODE_BACKSPACE; n_res = 2'd1; end
                  CHAR_LOWER_T: begin q_entry.char0 = CODE_TAB;       n_res = 2'd1; end
                  CHAR_LOWER_N: begin q_entry.char0 = CODE_NEWLINE;   n_res = 2'd1; end
                  CHAR_LOWER_F: begin q_entry.char0 = CODE_FORMFEED;  n_res = 2'd1; end
                  CHAR_LOWER_R: begin q_entry.char0 = CODE_RETURN;    n_res = 2'd1; end
                  CHAR_LOWER_X: begin
                     mode_in  = MODE_HEX;
                     value_in = '0;
                     count_in = '0;
                  end
                  default: begin
                     // drop unknown escapes, start an octal run on an octal digit
                     if (is_oct) begin
                        mode_in  = MODE_OCT;
                        value_in = {6'd0, req_ch.in_char[2:0]};
                        count_in = 2'd1;
                     end
                  end
               endcase
            end
            MODE_HEX, MODE_OCT: begin
               if ((mode_ff == MODE_HEX && hex_d[4]) || (mode_ff == MODE_OCT && is_oct)) begin
                  value_in = (mode_ff == MODE_HEX) ? hex_val : oct_val;
                  count_in = count_inc;
                  if ((mode_ff == MODE_HEX && count_inc >= HEX_FULL_COUNT) ||
                      (mode_ff == MODE_OCT && count_inc >= OCT_FULL_COUNT)) begin
                     q_entry.char0 = value_in;
                     n_res    = 2'd1;
                     mode_in  = MODE_NORMAL;
                     value_in = '0;
                     count_in = '0;
                  end
               end else begin
                  // flush the gathered value, then treat the character as text
                  q_entry.char0 = value_ff;
                  n_res    = 2'd1;
                  mode_in  = MODE_NORMAL;
                  value_in = '0;
                  count_in = '0;
                  if (req_ch.in_char == CHAR_BACKSLASH) begin
                     mode_in = MODE_ESC;
                  end else begin
                     q_entry.char1 = c_ext;
                     q_entry.two   = 1'b1;
                     n_res = 2'd2;
                  end
               end
            end
            default: begin
               mode_in  = MODE_NORMAL;
               value_in = '0;
               count_in = '0;
            end
         endcase
      end

      if (req_ch.in_last) begin
         // a pending value can only exist when nothing was emitted this step
         if (mode_in == MODE_HEX || mode_in == MODE_OCT) begin
            q_entry.char0 = value_in;
            n_res = 2'd1;
         end
         if (n_res == 2'd0) begin
            q_entry.char0 = '0;
            q_entry.has0  = 1'b0;
            n_res = 2'd1;
         end
         q_entry.eos = 1'b1;
         mode_in  = MODE_NORMAL;
         value_in = '0;
         count_in = '0;
      end
   end

   assign q_push = accept && (n_res != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         value_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         value_ff <= value_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- design/esd_queue.sv -----
// Short queue of decoded steps between front and back end.
module esd_queue
   import esd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  esd_entry_type push_entry,
   input  logic          pop,
   output esd_entry_type head_entry,
   output esd_qstat_type stat
);

   esd_entry_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/esd_back.sv -----
// Back end: splits queued steps into single responses behind an output register.
module esd_back
   import esd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  esd_entry_type head_entry,
   input  esd_qstat_type q_stat,
   output logic          pop,
   esd_rsp_if.source     rsp_ch
);

   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] char_ff, char_in;
   logic             has_ff, has_in;
   logic             eos_ff, eos_in;
   logic             second_ff, second_in;
   logic             load;

   assign load = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      has_in       = has_ff;
      eos_in       = eos_ff;
      second_in    = second_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = !q_stat.empty;
         if (!q_stat.empty) begin
            if (head_entry.two && !second_ff) begin
               // hold the entry for its second result
               char_in   = head_entry.char0;
               has_in    = head_entry.has0;
               eos_in    = 1'b0;
               second_in = 1'b1;
            end else begin
               char_in   = second_ff ? head_entry.char1 : head_entry.char0;
               has_in    = second_ff ? 1'b1 : head_entry.has0;
               eos_in    = head_entry.eos;
               second_in = 1'b0;
               pop       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      has_ff  <= has_in;
      eos_ff  <= eos_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.out_char      = char_ff;
   assign rsp_ch.has_char      = has_ff;
   assign rsp_ch.end_of_string = eos_ff;

endmodule

// ----- design/escape_sequence_decoder.sv -----
// Escape sequence decoder top level: front end, step queue and back end.
// Path: a character's first result is written into the queue, then loaded into the output
// register, and is driven on rsp from there.
// Throughput: one character per cycle unless the queue is full; the back end's output register
// sends one result per cycle unless rsp stalls; a 4-entry queue absorbs steps with two results.
// Reset: synchronous, active high; clears decode state, queue and output valid,
// and sets escape_enable to 1.
module escape_sequence_decoder
   import esd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   esd_csr_if.sink   csr_ch,
   esd_req_if.sink   req_ch,
   esd_rsp_if.source rsp_ch
);

   logic          escape_enable_ff, escape_enable_in;
   logic          q_push, q_pop;
   esd_entry_type q_entry, head_entry;
   esd_qstat_type q_stat;

   assign csr_ch.ready     = 1'b1;
   assign escape_enable_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.escape_enable
                                                            : escape_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_enable_ff <= 1'b1;
      end else begin
         escape_enable_ff <= escape_enable_in;
      end
   end

   esd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .escape_enable (escape_enable_ff),
      .q_stat        (q_stat),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   esd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .stat       (q_stat)
   );

   esd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_stat     (q_stat),
      .pop        (q_pop),
      .rsp_ch     (rsp_ch)
   );

`ifndef SYNTH
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("step pushed into a full queue");

   a_bare_marker_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.has_char) |-> (rsp_ch.end_of_string && rsp_ch.out_char == '0))
      else $error("bare marker without end of string or with a character");

   a_passthrough_single: assert property (@(posedge clock) disable iff (reset)
      (q_push && !escape_enable_ff) |-> (q_entry.has0 && !q_entry.two))
      else $error("pass-through step not a single character");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("pop from an empty queue");
`endif

endmodule

// ----- verif/escape_sequence_checker.sv -----
// Escape sequence decoder checker: predicts decoded characters and compares the response stream.
`timescale 1ns / 100ps

module escape_sequence_checker
   import esd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   esd_csr_if   csr_ch,
   esd_req_if   req_ch,
   esd_rsp_if   rsp_ch,
   output int   pending,
   output int   mismatches
);

   typedef struct packed {
      logic [OUT_W-1:0] code;
      logic             has;
      logic             eos;
   } decoded_char_type;

   decoded_char_type expected_chars[$];
   decoded_char_type step_chars[0:1];
   int               step_count;

   logic             escape_on;
   esd_mode_type     mode;
   logic [OUT_W-1:0] gathered;
   logic [1:0]       digits;

   task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                  input logic [OUT_W-1:0] want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic emit(input logic [OUT_W-1:0] code, input logic has);
      step_chars[step_count] = {code, has, 1'b0};
      step_count++;
   endtask

   task automatic restart();
      mode     = MODE_NORMAL;
      gathered = '0;
      digits   = '0;
   endtask

   task automatic plain_char(input logic [CHAR_W-1:0] c);
      if (c == CHAR_BACKSLASH) begin
         mode = MODE_ESC;
      end else begin
         emit({1'b0, c}, 1'b1);
      end
   endtask

   function automatic logic hex_value(input logic [CHAR_W-1:0] c, output logic [3:0] v);
      logic [CHAR_W-1:0] off;
      off = '0;
      v   = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         off = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         off = c - 8'h37;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         off = c - 8'h57;
      end else begin
         return 1'b0;
      end
      v = off[3:0];
      return 1'b1;
   endfunction

   // Work out every character that one accepted input gives and queue them in order
   task automatic decode_char(input logic [CHAR_W-1:0] c, input logic last);
      logic [3:0] nib;
      step_count = 0;
      nib        = '0;
      if (!escape_on) begin
         restart();
         emit({1'b0, c}, 1'b1);
      end else begin
         case (mode)
            MODE_NORMAL: plain_char(c);
            MODE_ESC: begin
               mode = MODE_NORMAL;
               case (c)
                  CHAR_LOWER_B: emit(CODE_BACKSPACE, 1'b1);
                  CHAR_LOWER_T: emit(CODE_TAB, 1'b1);
                  CHAR_LOWER_N: emit(CODE_NEWLINE, 1'b1);
                  CHAR_LOWER_F: emit(CODE_FORMFEED, 1'b1);
                  CHAR_LOWER_R: emit(CODE_RETURN, 1'b1);
                  CHAR_LOWER_X: begin
                     mode     = MODE_HEX;
                     gathered = '0;
                     digits   = '0;
                  end
                  default: begin
                     // anything else escaped is dropped, apart from an octal lead digit
                     if (c >= CHAR_ZERO && c <= CHAR_SEVEN) begin
                        mode     = MODE_OCT;
                        gathered = OUT_W'(c[2:0]);
                        digits   = 2'd1;
                     end
                  end
               endcase
            end
            MODE_HEX: begin
               if (hex_value(c, nib)) begin
                  gathered = {gathered[4:0], nib};
                  digits++;
                  if (digits == HEX_FULL_COUNT) begin
                     emit(gathered, 1'b1);
                     restart();
                  end
               end else begin
                  // flush what was gathered, then treat the terminator as ordinary text
                  emit(gathered, 1'b1);
                  restart();
                  plain_char(c);
               end
            end
            MODE_OCT: begin
               if (c >= CHAR_ZERO && c <= CHAR_SEVEN) begin
                  gathered = {gathered[5:0], c[2:0]};
                  digits++;
                  if (digits == OCT_FULL_COUNT) begin
                     emit(gathered, 1'b1);
                     restart();
                  end
               end else begin
                  emit(gathered, 1'b1);
                  restart();
                  plain_char(c);
               end
            end
            default: restart();
         endcase
      end
      if (last) begin
         if (mode == MODE_HEX || mode == MODE_OCT) begin
            emit(gathered, 1'b1);
         end
         restart();
         if (step_count == 0) begin
            emit('0, 1'b0);
         end
         step_chars[step_count-1].eos = 1'b1;
      end
      for (int i = 0; i < step_count; i++) begin
         expected_chars.push_back(step_chars[i]);
      end
   endtask

   task automatic check_result();
      decoded_char_type want;
      if (expected_chars.size() == 0) begin
         report_mismatch("unexpected result", rsp_ch.out_char, '0);
      end else begin
         want = expected_chars.pop_front();
         if (rsp_ch.out_char !== want.code) begin
            report_mismatch("out_char", rsp_ch.out_char, want.code);
         end
         if (rsp_ch.has_char !== want.has) begin
            report_mismatch("has_char", OUT_W'(rsp_ch.has_char), OUT_W'(want.has));
         end
         if (rsp_ch.end_of_string !== want.eos) begin
            report_mismatch("end_of_string", OUT_W'(rsp_ch.end_of_string), OUT_W'(want.eos));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         escape_on  = 1'b1;
         restart();
         expected_chars.delete();
         pending    = 0;
         mismatches = 0;
      end else begin
         // results pass through the queue and the output register before they appear, so check before predicting
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_result();
         end
         if (req_ch.valid && req_ch.ready) begin
            decode_char(req_ch.in_char, req_ch.in_last);
         end
         // a register write only affects transactions after this edge
         if (csr_ch.valid && csr_ch.ready) begin
            escape_on = csr_ch.escape_enable;
         end
         pending = expected_chars.size();
      end
   end

endmodule

// ----- verif/escape_sequence_decoder_tb.sv -----
// Escape sequence decoder testbench top: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module escape_sequence_decoder_tb;
   import esd_pkg::*;

   localparam int          PHASE_ITEMS   = 50;
   localparam int          RANDOM_PHASES = 8;
   localparam int          SETTLE_CYCLES = 6;
   localparam logic [7:0]  CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0]  CHAR_LOWER_A  = 8'h61;

   typedef enum int {
      READY_ALWAYS,
      READY_TWO_IN_THREE,
      READY_RANDOM,
      READY_SPARSE
   } ready_pattern_type;

   logic        clock = 1'b0;
   logic        reset;
   int          pending;
   int          mismatches;
   int unsigned burst_left;
   int          item_count;
   logic [7:0]  text_q[$];

   esd_csr_if csr_ch();
   esd_req_if req_ch();
   esd_rsp_if rsp_ch();

   escape_sequence_decoder u_top (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   escape_sequence_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_ch     (csr_ch),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .pending    (pending),
      .mismatches (mismatches)
   );

   always #5 clock = ~clock;

   // Receiver back-pressure: switch between patterns, including stretches with no stall
   initial begin
      ready_pattern_type pattern;
      int unsigned       span;
      int unsigned       tick;
      rsp_ch.ready = 1'b0;
      tick         = 0;
      forever begin
         pattern = ready_pattern_type'($urandom_range(0, 3));
         span    = $urandom_range(8, 80);
         repeat (span) begin
            @(negedge clock);
            tick++;
            case (pattern)
               READY_ALWAYS:       rsp_ch.ready = 1'b1;
               READY_TWO_IN_THREE: rsp_ch.ready = (tick % 3) != 0;
               READY_RANDOM:       rsp_ch.ready = $urandom_range(0, 1) == 1;
               default:            rsp_ch.ready = (tick % 7) >= 5;
            endcase
         end
      end
   end

   task automatic send_char(input logic [7:0] c, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = $urandom_range(0, 4);
         if (gap != 0) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid   = 1'b1;
      req_ch.in_char = c;
      req_ch.in_last = last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      item_count++;
   endtask

   // Send the gathered text; close marks the final character as end of string
   task automatic send_queue(input logic close);
      for (int i = 0; i < text_q.size(); i++) begin
         send_char(text_q[i], close && (i == text_q.size() - 1));
      end
      text_q.delete();
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         text_q.push_back(s[i]);
      end
      send_queue(1'b1);
   endtask

   // Idle the sender, wait for all outstanding results, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      burst_left   = 0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_enable(input logic en);
      @(negedge clock);
      csr_ch.valid         = 1'b1;
      csr_ch.escape_enable = en;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   function automatic logic [7:0] random_hex_char();
      int unsigned d;
      d = $urandom_range(0, 21);
      if (d < 10) begin
         return CHAR_ZERO + 8'(d);
      end else if (d < 16) begin
         return CHAR_UPPER_A + 8'(d - 10);
      end
      return CHAR_LOWER_A + 8'(d - 16);
   endfunction

   function automatic logic [7:0] random_named_char();
      case ($urandom_range(0, 4))
         0:       return CHAR_LOWER_B;
         1:       return CHAR_LOWER_T;
         2:       return CHAR_LOWER_N;
         3:       return CHAR_LOWER_F;
         default: return CHAR_LOWER_R;
      endcase
   endfunction

   // Build one string from escape tokens with random content, plus some noise
   task automatic compose_string();
      int unsigned tokens;
      int unsigned k;
      tokens = $urandom_range(1, 5);
      repeat (tokens) begin
         case ($urandom_range(0, 9))
            0, 1, 2: text_q.push_back(8'($urandom_range(32, 126)));
            3: begin
               text_q.push_back(CHAR_BACKSLASH);
               text_q.push_back(random_named_char());
            end
            4, 5: begin
               text_q.push_back(CHAR_BACKSLASH);
               text_q.push_back(CHAR_LOWER_X);
               k = $urandom_range(0, 2);
               repeat (k) text_q.push_back(random_hex_char());
            end
            6, 7: begin
               text_q.push_back(CHAR_BACKSLASH);
               k = $urandom_range(1, 3);
               repeat (k) text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 7)));
            end
            8: begin
               text_q.push_back(CHAR_BACKSLASH);
               text_q.push_back(8'($urandom_range(0, 255)));
            end
            default: text_q.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      // now and then leave a lone backslash at the end
      if ($urandom_range(0, 7) == 0) begin
         text_q.push_back(CHAR_BACKSLASH);
      end
   endtask

   initial begin
      logic close;
      req_ch.valid         = 1'b0;
      req_ch.in_char       = '0;
      req_ch.in_last       = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.escape_enable = 1'b0;
      burst_left           = 0;
      item_count           = 0;
      reset                = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_enable(1'b1);
      send_text("\\n\\t\\b\\f\\r");
      send_text("\\xFf\\xg\\");
      send_text("\\777\\09\\3");
      send_text("\\q");
      send_text("\\x");
      text_q.push_back(8'h00);
      text_q.push_back(8'hFF);
      send_queue(1'b1);
      settle();
      write_enable(1'b0);
      send_text("\\n");

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         write_enable((phase % 3) != 2);
         item_count = 0;
         while (item_count < PHASE_ITEMS) begin
            compose_string();
            // the last string of a phase may be left without its end mark and carry over
            close = (item_count + text_q.size() < PHASE_ITEMS) || ($urandom_range(0, 1) == 1);
            send_queue(close);
         end
      end
      settle();

      if (mismatches == 0) begin
         $display("escape_sequence_decoder_tb passed");
      end else begin
         $display("escape_sequence_decoder_tb failed");
      end
      $finish;
   end

   // Hold-off well beyond the slowest correct run
   initial begin
      #(2_000_000);
      $display("escape_sequence_decoder_tb failed");
      $finish;
   end

endmodule
